FILE: src/lzgbd_pkg.sv
// ----------------------------------------------------------------------------
// lzgbd_pkg
// Shared codes for the gamma-length LZ block decompressor: request opcodes,
// decode phases and fixed stream constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lzgbd_pkg;

  // Request opcodes
  localparam logic OP_OFFER = 1'b0;  // offer one compressed byte
  localparam logic OP_DRAIN = 1'b1;  // emit one byte of a pending copy

  // Decode phases
  localparam logic [2:0] PH_FLAG     = 3'd0;
  localparam logic [2:0] PH_LEN_CONT = 3'd1;
  localparam logic [2:0] PH_LEN_DATA = 3'd2;
  localparam logic [2:0] PH_OFFSET   = 3'd3;
  localparam logic [2:0] PH_EXTRA    = 3'd4;
  localparam logic [2:0] PH_LITERAL  = 3'd5;

  // Stream constants
  localparam logic [15:0] END_MARK     = 16'd65535;
  localparam logic [11:0] PRODUCED_MAX = 12'd4095;
  localparam logic [2:0]  EXTRA_BITS   = 3'd4;

endpackage

`default_nettype wire

FILE: src/lzgbd_ram.sv
// ----------------------------------------------------------------------------
// lzgbd_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lzgbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(Depth)-1:0]  waddr_i,
  input  wire [Width-1:0]          wdata_i,
  input  wire                      re_i,
  input  wire [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/lz_gamma_block_decompressor_core.sv
// ----------------------------------------------------------------------------
// lz_gamma_block_decompressor_core
// LZ decompressor with gamma-coded match lengths. Control bits come MSB
// first from bit bytes fetched lazily out of the compressed stream; matches
// copy from a history window held in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  request  | in_valid_i / in_stall_o   | opcode_i, data_byte_i
//  result   | res_valid_o / res_stall_i | out_valid_o, out_byte_o,
//           |                           | byte_taken_o, block_end_o,
//           |                           | bad_distance_o
//
//  One request at a time; every request gives exactly one result.
//  Drain and refused/no-op requests: accept, then history read-modify-write
//  or finish. Offer requests: accept, one step per control bit taken (a bit
//  byte fetch rides along with its first bit), plus one when a literal or
//  offset byte is consumed, then finish. No clearing pass after reset: a
//  copy from unwritten history gives a flagged zero byte. A stalled result
//  holds in the output register; a new request can be accepted while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module lz_gamma_block_decompressor_core #(
  parameter int WINDOW_DEPTH = 2048
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  // request channel
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire        opcode_i,
  input  wire [7:0]  data_byte_i,
  // result channel
  output logic       res_valid_o,
  input  wire        res_stall_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       byte_taken_o,
  output logic       block_end_o,
  output logic       bad_distance_o
);

  import lzgbd_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam logic [AW:0]   DepthExt = (AW+1)'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(WINDOW_DEPTH - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ZERO   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_DECODE = 2'd3;

  // Control and decoder state
  logic [1:0]    state_q, state_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] cp_q, cp_d;
  logic [11:0]   produced_q, produced_d;
  logic [7:0]    bitbuf_q, bitbuf_d;
  logic [3:0]    bits_q, bits_d;
  logic [2:0]    phase_q, phase_d;
  logic [15:0]   len_q, len_d;
  logic [10:0]   ofs_q, ofs_d;
  logic [2:0]    extra_q, extra_d;
  logic [15:0]   copy_rem_q, copy_rem_d;
  logic          used_q, used_d;
  logic          lit_valid_q, lit_valid_d;
  logic [7:0]    lit_byte_q, lit_byte_d;
  logic          bend_q, bend_d;
  logic [7:0]    byte_q, byte_d;

  // Output register
  logic          res_valid_q, res_valid_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          taken_q, taken_d;
  logic          oend_q, oend_d;
  logic          bad_q, bad_d;

  // History RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Decode step temporaries
  logic          out_free;
  logic          finish;
  logic          fin_valid, fin_taken, fin_bend, fin_bad;
  logic [7:0]    fin_byte;
  logic [7:0]    buf_eff;
  logic [3:0]    bits_eff;
  logic          bit_v;
  logic [2:0]    eff_phase;
  logic [15:0]   len_shift;
  logic [2:0]    ext_e;
  logic [10:0]   ofs_new;
  logic [11:0]   copy_dist;
  logic          is_bad;

  lzgbd_ram #(
    .Width (8),
    .Depth (WINDOW_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Advance a window pointer with wrap
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LastAddr) ? '0 : p + 1'b1;
  endfunction

  // Copy source: write pointer minus distance, modulo the window depth
  function automatic logic [AW-1:0] back_ptr(input logic [AW-1:0] wp,
                                              input logic [10:0]   ofs);
    logic [AW:0] wp_ext;
    logic [AW:0] d_ext;
    logic [AW:0] diff;
    wp_ext = {1'b0, wp};
    d_ext  = (AW+1)'({1'b0, ofs} + 12'd1);
    if (wp_ext >= d_ext) begin
      diff = wp_ext - d_ext;
    end else begin
      diff = wp_ext + DepthExt - d_ext;
    end
    back_ptr = diff[AW-1:0];
  endfunction

  assign out_free   = !res_valid_q || !res_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign copy_dist  = {1'b0, ofs_q} + 12'd1;
  assign is_bad     = (copy_dist > produced_q);

  // Sequencer and decoder next state
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    cp_d        = cp_q;
    produced_d  = produced_q;
    bitbuf_d    = bitbuf_q;
    bits_d      = bits_q;
    phase_d     = phase_q;
    len_d       = len_q;
    ofs_d       = ofs_q;
    extra_d     = extra_q;
    copy_rem_d  = copy_rem_q;
    used_d      = used_q;
    lit_valid_d = lit_valid_q;
    lit_byte_d  = lit_byte_q;
    bend_d      = bend_q;
    byte_d      = byte_q;

    ram_we      = 1'b0;
    ram_waddr   = wp_q;
    ram_wdata   = byte_q;
    ram_re      = 1'b0;
    ram_raddr   = cp_q;

    finish      = 1'b0;
    fin_valid   = 1'b0;
    fin_byte    = 8'd0;
    fin_taken   = 1'b0;
    fin_bend    = 1'b0;
    fin_bad     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          byte_d = data_byte_i;
          if (opcode_i == OP_DRAIN && copy_rem_q != 16'd0) begin
            // issue the history read for the copy source
            ram_re  = 1'b1;
            state_d = ST_DRAIN;
          end else if (opcode_i == OP_OFFER && copy_rem_q == 16'd0) begin
            used_d      = 1'b0;
            lit_valid_d = 1'b0;
            lit_byte_d  = 8'd0;
            bend_d      = 1'b0;
            state_d     = ST_DECODE;
          end else begin
            state_d = ST_ZERO;
          end
        end
      end

      ST_ZERO: begin
        // refused byte or idle drain: all-zero result
        if (out_free) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_DRAIN: begin
        // write the copied byte back and advance the copy
        if (out_free) begin
          fin_valid  = 1'b1;
          fin_bad    = is_bad;
          fin_byte   = is_bad ? 8'd0 : ram_rdata;
          finish     = 1'b1;
          ram_we     = 1'b1;
          ram_wdata  = fin_byte;
          wp_d       = ptr_inc(wp_q);
          produced_d = (produced_q != PRODUCED_MAX) ? produced_q + 12'd1 : produced_q;
          cp_d       = ptr_inc(cp_q);
          copy_rem_d = copy_rem_q - 16'd1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        // ST_DECODE: one control bit or one stream byte per cycle
        if (copy_rem_q != 16'd0 ||
            ((phase_q == PH_LITERAL || phase_q == PH_OFFSET) && used_q) ||
            (phase_q != PH_LITERAL && phase_q != PH_OFFSET &&
             bits_q == 4'd0 && used_q)) begin
          if (out_free) begin
            finish    = 1'b1;
            fin_valid = lit_valid_q;
            fin_byte  = lit_byte_q;
            fin_taken = used_q;
            fin_bend  = bend_q;
            state_d   = ST_IDLE;
          end
        end else if (phase_q == PH_LITERAL) begin
          used_d      = 1'b1;
          ram_we      = 1'b1;
          ram_wdata   = byte_q;
          wp_d        = ptr_inc(wp_q);
          produced_d  = (produced_q != PRODUCED_MAX) ? produced_q + 12'd1 : produced_q;
          lit_valid_d = 1'b1;
          lit_byte_d  = byte_q;
          phase_d     = PH_FLAG;
        end else if (phase_q == PH_OFFSET) begin
          used_d = 1'b1;
          if (byte_q[7]) begin
            ofs_d   = {4'd0, byte_q[6:0]};
            extra_d = EXTRA_BITS;
            phase_d = PH_EXTRA;
          end else begin
            ofs_d      = {3'd0, byte_q};
            copy_rem_d = len_q;
            cp_d       = back_ptr(wp_q, {3'd0, byte_q});
            len_d      = 16'd1;
            phase_d    = PH_FLAG;
          end
        end else begin
          // take one control bit, fetching a bit byte when empty
          if (bits_q == 4'd0) begin
            used_d = 1'b1;
          end
          bitbuf_d = {buf_eff[6:0], 1'b0};
          bits_d   = bits_eff - 4'd1;
          case (eff_phase)
            PH_FLAG: begin
              if (bit_v) begin
                len_d   = 16'd1;
                phase_d = PH_LEN_CONT;
              end else begin
                phase_d = PH_LITERAL;
              end
            end
            PH_LEN_CONT: begin
              if (bit_v) begin
                phase_d = PH_LEN_DATA;
              end else begin
                len_d   = len_q + 16'd1;
                phase_d = PH_OFFSET;
              end
            end
            PH_LEN_DATA: begin
              if (len_shift == END_MARK) begin
                // end marker: empty the bit buffer
                bend_d   = 1'b1;
                bitbuf_d = 8'd0;
                bits_d   = 4'd0;
                len_d    = 16'd1;
                phase_d  = PH_FLAG;
              end else begin
                len_d   = len_shift;
                phase_d = PH_LEN_CONT;
              end
            end
            default: begin
              // extra high offset bits
              ofs_d   = ofs_new;
              extra_d = ext_e - 3'd1;
              if (ext_e == 3'd1) begin
                copy_rem_d = len_q;
                cp_d       = back_ptr(wp_q, ofs_new);
                len_d      = 16'd1;
                phase_d    = PH_FLAG;
              end
            end
          endcase
        end
      end
    endcase
  end

  // Bit source and per-phase arithmetic for one decode step
  always_comb begin
    buf_eff   = (bits_q == 4'd0) ? byte_q : bitbuf_q;
    bits_eff  = (bits_q == 4'd0) ? 4'd8 : bits_q;
    bit_v     = buf_eff[7];
    eff_phase = (phase_q > PH_LITERAL) ? PH_FLAG : phase_q;
    len_shift = {len_q[14:0], bit_v};
    ext_e     = (extra_q < 3'd1 || extra_q > EXTRA_BITS) ? 3'd1 : extra_q;
    ofs_new   = ofs_q + (11'(bit_v) << (4'd6 + {1'b0, ext_e}));
  end

  // Load the result register, drop it when taken
  always_comb begin
    res_valid_d = res_valid_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    taken_d     = taken_q;
    oend_d      = oend_q;
    bad_d       = bad_q;
    if (finish) begin
      res_valid_d = 1'b1;
      out_valid_d = fin_valid;
      out_byte_d  = fin_byte;
      taken_d     = fin_taken;
      oend_d      = fin_bend;
      bad_d       = fin_bad;
    end else if (res_valid_q && !res_stall_i) begin
      res_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      cp_q        <= '0;
      produced_q  <= 12'd0;
      bitbuf_q    <= 8'd0;
      bits_q      <= 4'd0;
      phase_q     <= PH_FLAG;
      len_q       <= 16'd1;
      ofs_q       <= 11'd0;
      extra_q     <= 3'd0;
      copy_rem_q  <= 16'd0;
      used_q      <= 1'b0;
      lit_valid_q <= 1'b0;
      bend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      cp_q        <= cp_d;
      produced_q  <= produced_d;
      bitbuf_q    <= bitbuf_d;
      bits_q      <= bits_d;
      phase_q     <= phase_d;
      len_q       <= len_d;
      ofs_q       <= ofs_d;
      extra_q     <= extra_d;
      copy_rem_q  <= copy_rem_d;
      used_q      <= used_d;
      lit_valid_q <= lit_valid_d;
      bend_q      <= bend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lit_byte_q  <= lit_byte_d;
    byte_q      <= byte_d;
    out_valid_q <= out_valid_d;
    out_byte_q  <= out_byte_d;
    taken_q     <= taken_d;
    oend_q      <= oend_d;
    bad_q       <= bad_d;
  end

  assign res_valid_o    = res_valid_q;
  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign byte_taken_o   = taken_q;
  assign block_end_o    = oend_q;
  assign bad_distance_o = bad_q;

endmodule

`default_nettype wire

FILE: src/lzgbd_checker.sv
// ----------------------------------------------------------------------------
// lzgbd_checker
// Port-level checks for the decompressor core, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module lzgbd_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_stall_o,
  input wire       opcode_i,
  input wire [7:0] data_byte_i,
  input wire       res_valid_o,
  input wire       res_stall_i,
  input wire       out_valid_o,
  input wire [7:0] out_byte_o,
  input wire       byte_taken_o,
  input wire       block_end_o,
  input wire       bad_distance_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(out_valid_o) &&
    $stable(out_byte_o) && $stable(byte_taken_o) && $stable(block_end_o) &&
    $stable(bad_distance_o))
    else $error("stalled result changed");

  // One request at a time: an accepted request blocks the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one in flight");

  // A bad distance comes only from a drain: a zero byte, nothing consumed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && bad_distance_o |->
    out_valid_o && out_byte_o == 8'd0 && !byte_taken_o && !block_end_o)
    else $error("bad distance result malformed");

  // A result without an output byte carries a zero byte and no bad flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_byte_o == 8'd0 && !bad_distance_o)
    else $error("empty result carries data");

endmodule

bind lz_gamma_block_decompressor_core lzgbd_checker u_lzgbd_checker (.*);

`default_nettype wire
